>>> hw/rtl/rau_pkg.sv
// Shared definitions for the rational arithmetic unit: widths, function and
// error codes, and the status bundle of the iterative units.
// No dependencies; every other file of the block imports this package.
package rau_pkg;

   // Operands are taken as this many bits of each 16-bit field.
   localparam int OPERAND_WIDTH = 16;
   localparam int FIELD_WIDTH   = 16;
   localparam int FUNC_WIDTH    = 3;
   localparam int RES_WIDTH     = 32;

   localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
   localparam int SUM_WIDTH     = PROD_WIDTH + 1;
   localparam int CMP_WIDTH     = ((PROD_WIDTH > RES_WIDTH) ? PROD_WIDTH : RES_WIDTH) + 1;
   localparam int CNT_WIDTH     = $clog2(PROD_WIDTH + 1);

   localparam int REQ_DATA_WIDTH = 4 * FIELD_WIDTH;
   localparam int RSP_USED_WIDTH = 2 * RES_WIDTH + 3;
   localparam int RSP_DATA_WIDTH = ((RSP_USED_WIDTH + 7) / 8) * 8;
   localparam int RSP_PAD_WIDTH  = RSP_DATA_WIDTH - RSP_USED_WIDTH;

   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_ADD   = 3'd0,
      FUNC_SUB   = 3'd1,
      FUNC_MUL   = 3'd2,
      FUNC_DIV   = 3'd3,
      FUNC_LESS  = 3'd4,
      FUNC_EQUAL = 3'd5,
      FUNC_NEG   = 3'd6,
      FUNC_INC   = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      ERR_NONE     = 2'd0,
      ERR_ZERO_DEN = 2'd1,
      ERR_OVERFLOW = 2'd2
   } err_type;

   // Magnitude of a product or of a sum of two products.
   typedef logic [PROD_WIDTH-1:0] mag_type;

   // Status of an iterative unit: busy while stepping, done for one cycle at the end.
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

>>> hw/rtl/rau_gcd.sv
// Binary greatest common divisor unit, one shift or one subtract per cycle.
// Depends on rau_pkg for the magnitude type and the status bundle.
module rau_gcd (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  rau_pkg::mag_type       x_val,
   input  rau_pkg::mag_type       y_val,
   output rau_pkg::mag_type       gcd_val,
   output rau_pkg::unit_stat_type stat
);
   import rau_pkg::*;

   mag_type               x_ff;
   mag_type               y_ff;
   mag_type               g_ff;
   logic [CNT_WIDTH-1:0]  sh_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic                  finish;

   // Either value at zero ends the run; the other one, restored by the common
   // power of two, is the divisor.
   assign finish = busy_ff && ((x_ff == '0) || (y_ff == '0));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= finish;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (finish) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff  <= x_val;
         y_ff  <= y_val;
         sh_ff <= '0;
      end else if (busy_ff) begin
         if (x_ff == '0) begin
            g_ff <= y_ff;
         end else if (y_ff == '0) begin
            g_ff <= x_ff << sh_ff;
         end else if (!x_ff[0] && !y_ff[0]) begin
            x_ff  <= x_ff >> 1;
            y_ff  <= y_ff >> 1;
            sh_ff <= sh_ff + CNT_WIDTH'(1);
         end else if (!x_ff[0]) begin
            x_ff <= x_ff >> 1;
         end else if (!y_ff[0]) begin
            y_ff <= y_ff >> 1;
         end else if (x_ff > y_ff) begin
            x_ff <= y_ff;
            y_ff <= x_ff - y_ff;
         end else begin
            y_ff <= y_ff - x_ff;
         end
      end
   end

   assign gcd_val   = g_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

>>> hw/rtl/rau_div.sv
// Restoring divider with two lanes sharing one divisor, one quotient bit per cycle.
// Depends on rau_pkg for the magnitude type, counter width and status bundle.
module rau_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  rau_pkg::mag_type       num_val,
   input  rau_pkg::mag_type       den_val,
   input  rau_pkg::mag_type       divisor,
   output rau_pkg::mag_type       num_quo,
   output rau_pkg::mag_type       den_quo,
   output rau_pkg::unit_stat_type stat
);
   import rau_pkg::*;

   mag_type               div_ff;
   mag_type               nq_ff;
   mag_type               dq_ff;
   logic [PROD_WIDTH:0]   nr_ff;
   logic [PROD_WIDTH:0]   dr_ff;
   logic [CNT_WIDTH-1:0]  cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   logic [PROD_WIDTH:0]   nr_sh;
   logic [PROD_WIDTH:0]   dr_sh;
   logic [PROD_WIDTH:0]   div_ext;
   logic                  n_ge;
   logic                  d_ge;
   logic                  last_step;

   // Each lane brings down the next dividend bit and trial-subtracts the divisor.
   always_comb begin
      div_ext = {1'b0, div_ff};
      nr_sh   = {nr_ff[PROD_WIDTH-1:0], nq_ff[PROD_WIDTH-1]};
      dr_sh   = {dr_ff[PROD_WIDTH-1:0], dq_ff[PROD_WIDTH-1]};
      n_ge    = nr_sh >= div_ext;
      d_ge    = dr_sh >= div_ext;
   end

   assign last_step = busy_ff && (cnt_ff == CNT_WIDTH'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= last_step;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (last_step) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         div_ff <= divisor;
         nq_ff  <= num_val;
         dq_ff  <= den_val;
         nr_ff  <= '0;
         dr_ff  <= '0;
         cnt_ff <= CNT_WIDTH'(PROD_WIDTH);
      end else if (busy_ff) begin
         nr_ff  <= n_ge ? (nr_sh - div_ext) : nr_sh;
         dr_ff  <= d_ge ? (dr_sh - div_ext) : dr_sh;
         nq_ff  <= {nq_ff[PROD_WIDTH-2:0], n_ge};
         dq_ff  <= {dq_ff[PROD_WIDTH-2:0], d_ge};
         cnt_ff <= cnt_ff - CNT_WIDTH'(1);
      end
   end

   assign num_quo   = nq_ff;
   assign den_quo   = dq_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

>>> hw/rtl/rational_arithmetic_unit.sv
// Top level of the rational arithmetic unit: handshakes, sequencer, shared
// multiplier and result register. Depends on rau_pkg, rau_gcd and rau_div.
//
//  Channel  Direction  Handshake              Payload
//  req      in         req_tvalid/req_tready  tuser: func; tdata: a_num a_den b_num b_den
//  rsp      out        rsp_tvalid/rsp_tready  tdata: res_num res_den truth error
//
// Steps per transaction: two products for comparisons; two products and a sum for increment;
// two or three products, a sum, the binary gcd at one shift or subtract a cycle and a
// 32-step two-lane divide for the reducing functions; the gcd sets the spread in duration.
// Reset is synchronous and active high and clears the sequencer and the result valid flag.
// req_tready is high only while the sequencer is idle; a finished result waits in the
// sequencer only while the previous one still sits unaccepted in the output register.
module rational_arithmetic_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // From bit 0: a_num[15:0], a_den[31:16], b_num[47:32], b_den[63:48].
   input  logic [rau_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // func[2:0].
   input  logic [rau_pkg::FUNC_WIDTH-1:0]     req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // From bit 0: res_num[31:0], res_den[63:32], truth[64], error[66:65], zeros above.
   output logic [rau_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import rau_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_GCD,
      ST_DIV,
      ST_FIN
   } state_type;

   localparam logic signed [OPERAND_WIDTH-1:0] OP_ONE       = 1;
   localparam logic signed [OPERAND_WIDTH-1:0] OP_MINUS_ONE = -1;

   state_type                         state_ff;
   func_type                          func_ff;
   logic signed [OPERAND_WIDTH-1:0]   a_num_ff;
   logic signed [OPERAND_WIDTH-1:0]   a_den_ff;
   logic signed [OPERAND_WIDTH-1:0]   b_num_ff;
   logic signed [OPERAND_WIDTH-1:0]   b_den_ff;
   logic [1:0]                        mul_idx_ff;
   logic signed [PROD_WIDTH-1:0]      p0_ff;
   logic signed [PROD_WIDTH-1:0]      p1_ff;
   logic signed [PROD_WIDTH-1:0]      p2_ff;
   logic                              nn_ff;
   logic                              dn_ff;
   mag_type                           nm_ff;
   mag_type                           dm_ff;
   err_type                           err_ff;
   logic                              gcd_start_ff;
   logic                              div_start_ff;

   logic                              rsp_valid_ff;
   logic [RES_WIDTH-1:0]              rsp_num_ff;
   logic [RES_WIDTH-1:0]              rsp_den_ff;
   logic                              rsp_truth_ff;
   err_type                           rsp_err_ff;

   logic signed [OPERAND_WIDTH-1:0]   mul_x;
   logic signed [OPERAND_WIDTH-1:0]   mul_y;
   logic signed [PROD_WIDTH-1:0]      mul_p;
   logic                              three_products;
   logic                              is_compare;
   logic                              mul_last;

   logic signed [SUM_WIDTH-1:0]       sum_s;
   logic signed [SUM_WIDTH-1:0]       den_s;
   mag_type                           sum_mag;
   mag_type                           den_mag;

   logic [RES_WIDTH-1:0]              fin_num;
   logic [RES_WIDTH-1:0]              fin_den;
   logic                              fin_truth;
   err_type                           fin_err;
   logic                              out_free;
   logic                              fin_load;

   mag_type                           gcd_val;
   mag_type                           num_quo;
   mag_type                           den_quo;
   unit_stat_type                     gcd_stat;
   unit_stat_type                     div_stat;

   // A magnitude fits the result if it lies within 32-bit two's complement
   // for its sign.
   function automatic logic fits_res(logic neg, mag_type mag);
      logic [CMP_WIDTH-1:0] lim;
      lim = CMP_WIDTH'(1) << (RES_WIDTH - 1);
      if (!neg) begin
         lim = lim - CMP_WIDTH'(1);
      end
      return CMP_WIDTH'(mag) <= lim;
   endfunction

   function automatic logic [RES_WIDTH-1:0] enc_res(logic neg, mag_type mag);
      logic [CMP_WIDTH-1:0] ext;
      ext = CMP_WIDTH'(mag);
      if (neg) begin
         ext = -ext;
      end
      return ext[RES_WIDTH-1:0];
   endfunction

   function automatic mag_type abs_mag(logic signed [SUM_WIDTH-1:0] s);
      logic signed [SUM_WIDTH-1:0] a;
      a = s[SUM_WIDTH-1] ? -s : s;
      return a[PROD_WIDTH-1:0];
   endfunction

   assign three_products = (func_ff == FUNC_ADD) || (func_ff == FUNC_SUB);
   assign is_compare     = (func_ff == FUNC_LESS) || (func_ff == FUNC_EQUAL);
   assign mul_last       = (mul_idx_ff == 2'd2) || ((mul_idx_ff == 2'd1) && !three_products);

   // Operand pairs for the shared multiplier. Negate and increment pass the
   // left operand through it by multiplying with minus one or one, so that
   // every function lands in the same product registers.
   always_comb begin
      mul_x = a_den_ff;
      mul_y = b_den_ff;
      case (mul_idx_ff)
         2'd0: begin
            mul_x = a_num_ff;
            case (func_ff) inside
               FUNC_MUL: mul_y = b_num_ff;
               FUNC_NEG: mul_y = OP_MINUS_ONE;
               FUNC_INC: mul_y = OP_ONE;
               default:  mul_y = b_den_ff;
            endcase
         end
         2'd1: begin
            mul_x = a_den_ff;
            case (func_ff) inside
               FUNC_MUL:           mul_y = b_den_ff;
               FUNC_NEG, FUNC_INC: mul_y = OP_ONE;
               default:            mul_y = b_num_ff;
            endcase
         end
         default: begin
            mul_x = a_den_ff;
            mul_y = b_den_ff;
         end
      endcase
   end

   assign mul_p = PROD_WIDTH'(mul_x) * PROD_WIDTH'(mul_y);

   // Numerator and denominator before reduction.
   always_comb begin
      case (func_ff) inside
         FUNC_ADD, FUNC_INC: sum_s = SUM_WIDTH'(p0_ff) + SUM_WIDTH'(p1_ff);
         FUNC_SUB:           sum_s = SUM_WIDTH'(p0_ff) - SUM_WIDTH'(p1_ff);
         default:            sum_s = SUM_WIDTH'(p0_ff);
      endcase
      den_s   = three_products ? SUM_WIDTH'(p2_ff) : SUM_WIDTH'(p1_ff);
      sum_mag = abs_mag(sum_s);
      den_mag = abs_mag(den_s);
   end

   // Final result: comparison outcome, error code or the encoded pair.
   always_comb begin
      fin_num   = '0;
      fin_den   = '0;
      fin_truth = 1'b0;
      fin_err   = ERR_NONE;
      if (func_ff == FUNC_LESS) begin
         fin_truth = p0_ff < p1_ff;
      end else if (func_ff == FUNC_EQUAL) begin
         fin_truth = p0_ff == p1_ff;
      end else if (err_ff == ERR_ZERO_DEN) begin
         fin_err = ERR_ZERO_DEN;
      end else if (!fits_res(nn_ff, nm_ff) || !fits_res(dn_ff, dm_ff)) begin
         fin_err = ERR_OVERFLOW;
      end else begin
         fin_num = enc_res(nn_ff, nm_ff);
         fin_den = enc_res(dn_ff, dm_ff);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;
   // The output register takes a new result in the same cycle as the old one leaves.
   assign fin_load = (state_ff == ST_FIN) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         gcd_start_ff <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         gcd_start_ff <= (state_ff == ST_SUM) && (den_mag != '0) && (func_ff != FUNC_INC);
         div_start_ff <= (state_ff == ST_GCD) && gcd_stat.done;
         if (fin_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  func_ff    <= func_type'(req_tuser);
                  a_num_ff   <= OPERAND_WIDTH'(req_tdata[FIELD_WIDTH-1:0]);
                  a_den_ff   <= OPERAND_WIDTH'(req_tdata[2*FIELD_WIDTH-1:FIELD_WIDTH]);
                  b_num_ff   <= OPERAND_WIDTH'(req_tdata[3*FIELD_WIDTH-1:2*FIELD_WIDTH]);
                  b_den_ff   <= OPERAND_WIDTH'(req_tdata[4*FIELD_WIDTH-1:3*FIELD_WIDTH]);
                  mul_idx_ff <= 2'd0;
                  err_ff     <= ERR_NONE;
                  state_ff   <= ST_MUL;
               end
            end
            ST_MUL: begin
               case (mul_idx_ff)
                  2'd0:    p0_ff <= mul_p;
                  2'd1:    p1_ff <= mul_p;
                  default: p2_ff <= mul_p;
               endcase
               mul_idx_ff <= mul_idx_ff + 2'd1;
               if (mul_last) begin
                  state_ff <= is_compare ? ST_FIN : ST_SUM;
               end
            end
            ST_SUM: begin
               nn_ff <= sum_s[SUM_WIDTH-1];
               nm_ff <= sum_mag;
               dn_ff <= den_s[SUM_WIDTH-1];
               dm_ff <= den_mag;
               if (den_mag == '0) begin
                  err_ff   <= ERR_ZERO_DEN;
                  state_ff <= ST_FIN;
               end else if (func_ff == FUNC_INC) begin
                  state_ff <= ST_FIN;
               end else begin
                  state_ff <= ST_GCD;
               end
            end
            ST_GCD: begin
               if (gcd_stat.done) begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_stat.done) begin
                  nm_ff    <= num_quo;
                  dm_ff    <= den_quo;
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               if (out_free) begin
                  rsp_num_ff   <= fin_num;
                  rsp_den_ff   <= fin_den;
                  rsp_truth_ff <= fin_truth;
                  rsp_err_ff   <= fin_err;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   rau_gcd u_gcd (
      .clock   (clock),
      .reset   (reset),
      .start   (gcd_start_ff),
      .x_val   (nm_ff),
      .y_val   (dm_ff),
      .gcd_val (gcd_val),
      .stat    (gcd_stat)
   );

   rau_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start_ff),
      .num_val (nm_ff),
      .den_val (dm_ff),
      .divisor (gcd_val),
      .num_quo (num_quo),
      .den_quo (den_quo),
      .stat    (div_stat)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_WIDTH{1'b0}}, rsp_err_ff, rsp_truth_ff, rsp_den_ff, rsp_num_ff};

   // Once a transaction is taken the block must not take another until it is done.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken again straight after a transaction");

   // A zero denominator result carries zeros in both halves of the pair.
   a_zero_den_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_err_ff == ERR_ZERO_DEN))
         |-> ((rsp_num_ff == '0) && (rsp_den_ff == '0)))
      else $error("zero denominator result with non-zero pair");

   // A true comparison never comes with an error or a numerator.
   a_truth_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_truth_ff) |-> ((rsp_err_ff == ERR_NONE) && (rsp_num_ff == '0)))
      else $error("comparison result mixed with arithmetic result");

   // The gcd unit and the divider never run at the same time.
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({gcd_stat.busy, div_stat.busy}))
      else $error("gcd unit and divider busy together");

   // The gcd unit finishes only while the sequencer waits for it.
   a_gcd_done_in_state: assert property (@(posedge clock) disable iff (reset)
      gcd_stat.done |-> (state_ff == ST_GCD))
      else $error("gcd finished outside its sequencer state");

endmodule

>>> tb/sv/tb_rational_arithmetic_unit.sv
// Self-checking testbench for the rational arithmetic unit: directed and random
// transactions with an in-line predictor, random stalls on both channels and a long
// receiver hold-off. Depends on rau_pkg and rational_arithmetic_unit.
module tb_rational_arithmetic_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import rau_pkg::*;

   localparam int CLOCK_HALF      = 6;
   localparam int RESET_CYCLES    = 10;
   // The limit allows every transaction the time of the slowest one, plus long stalls
   // on both sides, several times over.
   localparam int CYCLE_LIMIT     = 1_500_000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 200;

   // One predicted response. The function code is kept only for reporting.
   typedef struct {
      func_type           func;
      logic signed [31:0] res_num;
      logic signed [31:0] res_den;
      logic               truth;
      err_type            error;
   } rational_result_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata;   // a_num, a_den, b_num, b_den from bit 0
   logic [FUNC_WIDTH-1:0]     req_tuser;   // func
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;   // res_num, res_den, truth, error, zeros

   rational_result_type pending_results[$];
   int unsigned    mismatches = 0;
   int unsigned    cycle_count = 0;
   int unsigned    sender_idle_pct = 0;
   int unsigned    receiver_idle_pct = 0;
   int unsigned    hold_off_requests = 0;
   int unsigned    hold_off_served = 0;
   int unsigned    hold_off_left = 0;

   rational_arithmetic_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL rational_arithmetic_unit");
         $finish;
      end
   end

   // Works out the response to one transaction. All operands are 16-bit, so every
   // product and sum fits comfortably in 64 bits and plain signed arithmetic gives
   // the same signs as the block's sign-magnitude datapath, zero included.
   function automatic rational_result_type predict_rational(input func_type func,
         input logic [15:0] a_num, a_den, b_num, b_den);
      rational_result_type r;
      longint         an, ad, bn, bd;
      longint         num, den, g, x, y, t;
      bit             do_reduce;
      bit             is_compare;
      an = longint'($signed(a_num));
      ad = longint'($signed(a_den));
      bn = longint'($signed(b_num));
      bd = longint'($signed(b_den));
      r.func = func;
      r.res_num = '0;
      r.res_den = '0;
      r.truth = 1'b0;
      r.error = ERR_NONE;
      num = 0;
      den = 0;
      do_reduce = 1'b1;
      is_compare = 1'b0;
      case (func)
         FUNC_ADD: begin
            num = an * bd + ad * bn;
            den = ad * bd;
         end
         FUNC_SUB: begin
            num = an * bd - ad * bn;
            den = ad * bd;
         end
         FUNC_MUL: begin
            num = an * bn;
            den = ad * bd;
         end
         FUNC_DIV: begin
            num = an * bd;
            den = ad * bn;
         end
         FUNC_LESS: begin
            is_compare = 1'b1;
            r.truth = (an * bd < ad * bn);
         end
         FUNC_EQUAL: begin
            is_compare = 1'b1;
            r.truth = (an * bd == ad * bn);
         end
         FUNC_NEG: begin
            num = -an;
            den = ad;
         end
         default: begin
            // Increment adds the denominator and leaves the fraction unreduced.
            num = an + ad;
            den = ad;
            do_reduce = 1'b0;
         end
      endcase
      if (!is_compare) begin
         if (den == 0) begin
            r.error = ERR_ZERO_DEN;
         end else begin
            if (do_reduce) begin
               // Euclid on the magnitudes; a zero numerator leaves 0 over +1 or -1.
               x = (num < 0) ? -num : num;
               y = (den < 0) ? -den : den;
               while (y != 0) begin
                  t = x % y;
                  x = y;
                  y = t;
               end
               g = x;
               num = num / g;
               den = den / g;
            end
            if (num < -64'sd2147483648 || num > 64'sd2147483647 ||
                den < -64'sd2147483648 || den > 64'sd2147483647) begin
               r.error = ERR_OVERFLOW;
            end else begin
               r.res_num = num[31:0];
               r.res_den = den[31:0];
            end
         end
      end
      return r;
   endfunction

   // Offers one transaction from a falling edge, with random gaps in front of it,
   // and returns at the falling edge after it has been taken. tvalid stays high
   // when the next transaction follows without a gap.
   task automatic send_operation(input func_type func,
         input logic [15:0] a_num, a_den, b_num, b_den);
      rational_result_type outcome;
      outcome = predict_rational(func, a_num, a_den, b_num, b_den);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {b_den, b_num, a_den, a_num};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(outcome);
      @(negedge clock);
   endtask

   // Operand values weighted towards the interesting corners: zero, one, the two
   // extremes, small values that share factors, powers of two and anything at all.
   function automatic logic [15:0] random_operand();
      logic [15:0] value;
      case ($urandom_range(9, 0))
         0, 1, 2, 3: value = 16'($urandom);
         4, 5, 6:    value = 16'($signed($urandom_range(40, 0)) - 20);
         7: begin
            case ($urandom_range(4, 0))
               0:       value = 16'h8000;
               1:       value = 16'h7FFF;
               2:       value = 16'hFFFF;
               3:       value = 16'h0001;
               default: value = 16'h0000;
            endcase
         end
         8:       value = 16'h0000;
         default: begin
            value = 16'h0001 << $urandom_range(15, 0);
            if ($urandom_range(1, 0) == 1) value = -value;
         end
      endcase
      return value;
   endfunction

   // Receiver: random stalls, or a long hold-off on request, counted here.
   always @(negedge clock) begin
      if (hold_off_served != hold_off_requests) begin
         hold_off_served = hold_off_requests;
         hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= receiver_idle_pct);
      end
   end

   task automatic check_field(input string field, input func_type func,
         input longint want, input longint got);
      if (want != got) begin
         $display("%0t ns: mismatch on %s (%s): expected %0d, actual %0d",
            $realtime, field, func.name(), want, got);
         mismatches++;
      end
   endtask

   // Response checker: every accepted response is compared with the oldest
   // prediction still waiting.
   always @(posedge clock) begin
      rational_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t ns: unexpected response: expected none, actual data %h",
               $realtime, rsp_tdata);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("res_num", want.func, longint'(want.res_num),
               longint'($signed(rsp_tdata[31:0])));
            check_field("res_den", want.func, longint'(want.res_den),
               longint'($signed(rsp_tdata[63:32])));
            check_field("truth", want.func, longint'(want.truth),
               longint'(rsp_tdata[64]));
            check_field("error", want.func, longint'(want.error),
               longint'(rsp_tdata[66:65]));
         end
      end
   end

   // Arithmetic functions: exact sums and products, zero results with either
   // denominator sign, zero denominators and the operand extremes.
   task automatic test_directed_arithmetic();
      send_operation(FUNC_ADD, 1, 2, 1, 3);
      send_operation(FUNC_ADD, 0, 1, 0, -3);
      send_operation(FUNC_ADD, 1, 0, 1, 3);
      send_operation(FUNC_ADD, -32768, -32768, -32768, -32768);
      send_operation(FUNC_SUB, 3, 4, 3, 4);
      send_operation(FUNC_SUB, 1, -2, 1, 2);
      send_operation(FUNC_MUL, -32768, 32767, -32768, 32767);
      send_operation(FUNC_MUL, 32767, -32768, 32767, -32768);
      send_operation(FUNC_DIV, 1, 2, 0, 5);
      send_operation(FUNC_DIV, -32768, 1, 1, -32768);
      send_operation(FUNC_DIV, 7, 3, -14, 9);
   endtask

   // Comparisons: both outcomes, signs in the denominators and zero denominators,
   // which are not errors here.
   task automatic test_directed_compare();
      send_operation(FUNC_LESS, 1, 2, 2, 3);
      send_operation(FUNC_LESS, -1, -2, 1, 2);
      send_operation(FUNC_LESS, 32767, -32768, -32768, 32767);
      send_operation(FUNC_EQUAL, 2, 4, 1, 2);
      send_operation(FUNC_EQUAL, 0, 0, 5, 0);
      send_operation(FUNC_EQUAL, 1, 3, 1, 4);
   endtask

   // Negate and increment: sign handling, the most negative operand, zero
   // denominators and the unreduced increment.
   task automatic test_directed_unary();
      send_operation(FUNC_NEG, 5, -10, 0, 0);
      send_operation(FUNC_NEG, 0, -7, 0, 0);
      send_operation(FUNC_NEG, -32768, 1, 0, 0);
      send_operation(FUNC_NEG, 3, 0, 0, 0);
      send_operation(FUNC_INC, 3, 4, 0, 0);
      send_operation(FUNC_INC, 5, 0, 0, 0);
      send_operation(FUNC_INC, -32768, -32768, 0, 0);
      send_operation(FUNC_INC, 32767, 32767, 32767, 32767);
   endtask

   // Random transactions over all functions. One in eight has b as a scaled copy
   // of a, so that equal comparisons and exact cancellations come up often.
   task automatic test_random(input int unsigned count, input int unsigned sender_pct,
         input int unsigned receiver_pct);
      func_type    func;
      logic [15:0] a_num, a_den, b_num, b_den;
      int          scale;
      sender_idle_pct = sender_pct;
      receiver_idle_pct = receiver_pct;
      repeat (count) begin
         func = func_type'($urandom_range(7, 0));
         a_num = random_operand();
         a_den = random_operand();
         b_num = random_operand();
         b_den = random_operand();
         if ($urandom_range(7, 0) == 0) begin
            case ($urandom_range(3, 0))
               0:       scale = 1;
               1:       scale = -1;
               2:       scale = 2;
               default: scale = 3;
            endcase
            b_num = 16'(int'($signed(a_num)) * scale);
            b_den = 16'(int'($signed(a_den)) * scale);
         end
         send_operation(func, a_num, a_den, b_num, b_den);
      end
   endtask

   // The receiver holds off for a long stretch while transactions keep coming, so
   // the output register and the sequencer fill up and req_tready drops.
   task automatic test_receiver_hold_off();
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      hold_off_requests <= hold_off_requests + 1;
      repeat (16) begin
         send_operation(func_type'($urandom_range(7, 0)), random_operand(),
            random_operand(), random_operand(), random_operand());
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      rsp_tready = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_arithmetic();
      test_directed_compare();
      test_directed_unary();
      test_receiver_hold_off();
      test_random(360, 13, 52);
      test_random(360, 52, 13);
      test_random(360, 0, 0);
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASS rational_arithmetic_unit");
      end else begin
         $display("FAIL rational_arithmetic_unit");
      end
      $finish;
   end

endmodule

>>> rational_arithmetic_unit.f
hw/rtl/rau_pkg.sv
hw/rtl/rau_gcd.sv
hw/rtl/rau_div.sv
hw/rtl/rational_arithmetic_unit.sv
tb/sv/tb_rational_arithmetic_unit.sv
